// ===== rtl/core/srb_pkg.sv =====
// Package with shared constants, payload types and codes of the sample ring buffer.
package srb_pkg;

  // Built depth of the sample memory and derived widths.
  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned MAX_READ = 64;

  // Fixed field widths of the interface.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned CAP_W    = 11;
  localparam int unsigned RC_W     = 7;
  localparam int unsigned DROP_W   = 32;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Operation codes of an input word.
  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_BURST = 1'b1
  } ctrl_state_e;

  // One input word.
  typedef struct packed {
    func_e               func;
    logic [SAMPLE_W-1:0] sample_in;
    logic [RC_W-1:0]     read_count;
  } cmd_t;

  // One result word.
  typedef struct packed {
    logic                ok;
    logic                has_sample;
    logic [SAMPLE_W-1:0] sample_out;
    logic                last;
    logic [CAP_W-1:0]    occupancy;
    logic [DROP_W-1:0]   dropped_total;
  } res_t;

  // Access request from the controller to the sample memory.
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } ram_req_t;

endpackage

// ===== rtl/core/srb_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
module srb_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 1024,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/srb_ctrl.sv =====
// Controller of the sample ring buffer: slots, fill level, drop counter and read bursts.
module srb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  srb_pkg::cmd_t                 cmd_i,
  output logic                          busy,
  input  logic                          cfg_valid_i,
  input  logic [srb_pkg::CAP_W-1:0]     cfg_data_i,
  output logic                          cfg_ready_o,
  output srb_pkg::ram_req_t             ram_req_o,
  output logic                          meta_valid_o,
  output srb_pkg::res_t                 meta_o
);

  srb_pkg::ctrl_state_e state_q, state_d;

  logic [srb_pkg::CAP_W-1:0]    cap_q, cap_d;
  logic [srb_pkg::ADDR_W-1:0]   wslot_q, wslot_d;
  logic [srb_pkg::ADDR_W-1:0]   rslot_q, rslot_d;
  logic [srb_pkg::CNT_W-1:0]    held_q, held_d;
  logic [srb_pkg::DROP_W-1:0]   drop_q, drop_d;
  logic [srb_pkg::RC_W-1:0]     rem_q, rem_d;
  logic                         meta_valid_q, meta_valid_d;
  srb_pkg::res_t                meta_q, meta_d;

  logic [srb_pkg::CNT_W-1:0]    cap_eff;
  logic [srb_pkg::CNT_W-1:0]    wslot_inc, rslot_inc;
  logic [srb_pkg::ADDR_W-1:0]   wslot_nxt, rslot_nxt;
  logic                         accept;
  logic                         is_read;
  logic                         rd_fail;
  logic                         rd_zero;
  logic                         cfg_we;

  // Capacity clamped to 1..DEPTH.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = srb_pkg::CNT_W'(1);
    end else if (32'(cap_q) > srb_pkg::DEPTH) begin
      cap_eff = srb_pkg::CNT_W'(srb_pkg::DEPTH);
    end else begin
      cap_eff = srb_pkg::CNT_W'(cap_q);
    end
  end

  // Slot advance with wrap at the capacity in use.
  assign wslot_inc = srb_pkg::CNT_W'(wslot_q) + srb_pkg::CNT_W'(1);
  assign rslot_inc = srb_pkg::CNT_W'(rslot_q) + srb_pkg::CNT_W'(1);
  assign wslot_nxt = (wslot_inc >= cap_eff) ? '0 : wslot_inc[srb_pkg::ADDR_W-1:0];
  assign rslot_nxt = (rslot_inc >= cap_eff) ? '0 : rslot_inc[srb_pkg::ADDR_W-1:0];

  // Decode of the incoming word.
  assign accept  = start && !busy;
  assign is_read = (cmd_i.func == srb_pkg::FUNC_READ);
  assign rd_fail = (32'(cmd_i.read_count) > srb_pkg::MAX_READ) ||
                   (32'(cmd_i.read_count) > 32'(held_q));
  assign rd_zero = (cmd_i.read_count == '0);
  assign cfg_we  = cfg_valid_i && cfg_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srb_pkg::ST_IDLE: begin
        if (accept && is_read && !rd_fail && (cmd_i.read_count > srb_pkg::RC_W'(1))) begin
          state_d = srb_pkg::ST_BURST;
        end
      end
      srb_pkg::ST_BURST: begin
        if (rem_q == srb_pkg::RC_W'(1)) begin
          state_d = srb_pkg::ST_IDLE;
        end
      end
      default: state_d = srb_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    case (state_q)
      srb_pkg::ST_IDLE:  busy = 1'b0;
      srb_pkg::ST_BURST: busy = 1'b1;
      default:           busy = 1'b1;
    endcase
    cfg_ready_o = !busy;
  end

  // Datapath: memory requests, slot and count updates, result metadata.
  always_comb begin
    cap_d        = cap_q;
    wslot_d      = wslot_q;
    rslot_d      = rslot_q;
    held_d       = held_q;
    drop_d       = drop_q;
    rem_d        = rem_q;
    meta_valid_d = 1'b0;
    meta_d       = meta_q;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = wslot_q;
    ram_req_o.wdata = cmd_i.sample_in;
    ram_req_o.re    = 1'b0;
    ram_req_o.raddr = rslot_q;

    if (state_q == srb_pkg::ST_BURST) begin
      // One sample of an ongoing burst per cycle.
      ram_req_o.re = 1'b1;
      rslot_d      = rslot_nxt;
      held_d       = held_q - srb_pkg::CNT_W'(1);
      rem_d        = rem_q - srb_pkg::RC_W'(1);
      meta_valid_d = 1'b1;
      meta_d.ok    = 1'b1;
      meta_d.has_sample = 1'b1;
      meta_d.last  = (rem_q == srb_pkg::RC_W'(1));
    end else if (accept) begin
      meta_valid_d      = 1'b1;
      meta_d.has_sample = 1'b0;
      meta_d.last       = 1'b1;
      if (!is_read) begin
        // Store the sample, or drop it when the ring is full.
        if (held_q < cap_eff) begin
          ram_req_o.we = 1'b1;
          wslot_d      = wslot_nxt;
          held_d       = held_q + srb_pkg::CNT_W'(1);
          meta_d.ok    = 1'b1;
        end else begin
          if (drop_q != '1) begin
            drop_d = drop_q + srb_pkg::DROP_W'(1);
          end
          meta_d.ok = 1'b0;
        end
      end else if (rd_fail) begin
        meta_d.ok = 1'b0;
      end else if (rd_zero) begin
        meta_d.ok = 1'b1;
      end else begin
        // First sample of a read burst.
        ram_req_o.re      = 1'b1;
        rslot_d           = rslot_nxt;
        held_d            = held_q - srb_pkg::CNT_W'(1);
        rem_d             = cmd_i.read_count - srb_pkg::RC_W'(1);
        meta_d.ok         = 1'b1;
        meta_d.has_sample = 1'b1;
        meta_d.last       = (cmd_i.read_count == srb_pkg::RC_W'(1));
      end
    end

    meta_d.sample_out    = '0;
    meta_d.occupancy     = srb_pkg::CAP_W'(held_d);
    meta_d.dropped_total = drop_d;

    // A capacity write empties the ring and keeps the drop count.
    if (cfg_we) begin
      cap_d   = cfg_data_i;
      wslot_d = '0;
      rslot_d = '0;
      held_d  = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= srb_pkg::ST_IDLE;
      cap_q        <= srb_pkg::CAP_RESET;
      wslot_q      <= '0;
      rslot_q      <= '0;
      held_q       <= '0;
      drop_q       <= '0;
      rem_q        <= '0;
      meta_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cap_q        <= cap_d;
      wslot_q      <= wslot_d;
      rslot_q      <= rslot_d;
      held_q       <= held_d;
      drop_q       <= drop_d;
      rem_q        <= rem_d;
      meta_valid_q <= meta_valid_d;
    end
  end

  // Result metadata register, aligned with the memory read data.
  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
  end

  assign meta_valid_o = meta_valid_q;
  assign meta_o       = meta_q;

endmodule

// ===== rtl/core/sample_ring_buffer.sv =====
// Top level of the sample ring buffer: controller, sample memory and result assembly.
//
// A word is taken when start is high and busy is low. A write does not raise busy, and a
// write may follow every cycle. A read of n samples (1 to 64), n above one, keeps busy
// high after it is taken until its last sample is issued, as samples come out of the
// single read port of the sample memory one per cycle; failed, zero-length and one-sample
// reads do not raise busy. Every result appears on res_o for exactly one cycle, marked by
// res_strobe_o, in the cycle after the cycle that issued it, and cannot be held off. The
// capacity register may be written only while no result is outstanding; a write
// empties the ring and keeps the drop count.
module sample_ring_buffer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  srb_pkg::cmd_t             cmd_i,
  output logic                      busy,
  input  logic                      cfg_valid_i,
  input  logic [srb_pkg::CAP_W-1:0] cfg_data_i,
  output logic                      cfg_ready_o,
  output logic                      res_strobe_o,
  output srb_pkg::res_t             res_o
);

  srb_pkg::ram_req_t               ram_req;
  srb_pkg::res_t                   meta;
  logic                            meta_valid;
  logic [srb_pkg::SAMPLE_W-1:0]    rdata;

  srb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .cmd_i        (cmd_i),
    .busy         (busy),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_ready_o  (cfg_ready_o),
    .ram_req_o    (ram_req),
    .meta_valid_o (meta_valid),
    .meta_o       (meta)
  );

  srb_ram #(
    .DATA_W (srb_pkg::SAMPLE_W),
    .DEPTH  (srb_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  // Merge the read data into the result word.
  always_comb begin
    res_o = meta;
    res_o.sample_out = meta.has_sample ? rdata : '0;
  end

  assign res_strobe_o = meta_valid;

  // A sample only comes with a successful read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.has_sample |-> res_o.ok)
    else $error("sample result without ok");

  // Every burst cycle issues a sample that shows up in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> res_strobe_o && res_o.has_sample)
    else $error("burst cycle without sample result");

  // The fill level never exceeds the built depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> 32'(res_o.occupancy) <= srb_pkg::DEPTH)
    else $error("occupancy above depth");

  // The drop count never goes down between back-to-back results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && $past(res_strobe_o) |->
      res_o.dropped_total >= $past(res_o.dropped_total))
    else $error("drop count decreased");

endmodule

// ===== tb/sv/sample_ring_buffer_test.sv =====
// Self-checking testbench of the sample ring buffer: a directed table, then random words.
`timescale 1ns / 100ps

module sample_ring_buffer_test;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned MAX_SHOWN    = 10;

  // Kinds of rows in the directed table.
  typedef enum logic {
    ROW_WORD,
    ROW_CAP
  } row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    srb_pkg::cmd_t             cmd;
    logic [srb_pkg::CAP_W-1:0] cap;
    bit                        typed;
    srb_pkg::res_t             want;
  } stim_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  srb_pkg::cmd_t             cmd_i;
  logic                      busy;
  logic                      cfg_valid_i;
  logic [srb_pkg::CAP_W-1:0] cfg_data_i;
  logic                      cfg_ready_o;
  logic                      res_strobe_o;
  srb_pkg::res_t             res_o;

  // Shadow copy of the ring, updated when a word or a capacity write is taken.
  logic [srb_pkg::SAMPLE_W-1:0] ring_mem [srb_pkg::DEPTH];
  logic [srb_pkg::ADDR_W-1:0]   ring_wr;
  logic [srb_pkg::ADDR_W-1:0]   ring_rd;
  logic [srb_pkg::CNT_W-1:0]    ring_held;
  logic [srb_pkg::CAP_W-1:0]    ring_cap;
  logic [srb_pkg::DROP_W-1:0]   ring_drops = '0;

  srb_pkg::res_t word_results[$];
  srb_pkg::res_t pending_results[$];
  int unsigned   mismatches = 0;
  int unsigned   cycles = 0;

  sample_ring_buffer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .cmd_i        (cmd_i),
    .busy         (busy),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_ready_o  (cfg_ready_o),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  // Free-running clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // A capacity of zero behaves as one, and anything above the built depth as the depth.
  function automatic int unsigned usable_slots(logic [srb_pkg::CAP_W-1:0] c);
    if (c == '0) return 1;
    if (32'(c) > srb_pkg::DEPTH) return srb_pkg::DEPTH;
    return 32'(c);
  endfunction

  function automatic logic [srb_pkg::ADDR_W-1:0] advance_slot(logic [srb_pkg::ADDR_W-1:0] s,
                                                              int unsigned c);
    int unsigned n;
    n = 32'(s) + 1;
    return (n >= c) ? '0 : srb_pkg::ADDR_W'(n);
  endfunction

  function automatic srb_pkg::res_t ring_result(logic ok, logic has,
                                                logic [srb_pkg::SAMPLE_W-1:0] s, logic lst);
    return srb_pkg::res_t'{ok: ok, has_sample: has, sample_out: s, last: lst,
                           occupancy: ring_held, dropped_total: ring_drops};
  endfunction

  task automatic empty_ring(logic [srb_pkg::CAP_W-1:0] c);
    ring_cap  = c;
    ring_wr   = '0;
    ring_rd   = '0;
    ring_held = '0;
  endtask

  // Works out the results of one taken word and advances the shadow ring.
  task automatic predict_ring_results(srb_pkg::cmd_t c);
    int unsigned                  cap;
    logic [srb_pkg::SAMPLE_W-1:0] v;
    cap = usable_slots(ring_cap);
    word_results.delete();
    if (c.func == srb_pkg::FUNC_WRITE) begin
      if (32'(ring_held) < cap) begin
        ring_mem[ring_wr] = c.sample_in;
        ring_wr = advance_slot(ring_wr, cap);
        ring_held++;
        word_results.push_back(ring_result(1'b1, 1'b0, '0, 1'b1));
      end else begin
        if (ring_drops != '1) ring_drops++;
        word_results.push_back(ring_result(1'b0, 1'b0, '0, 1'b1));
      end
    end else if (32'(c.read_count) > srb_pkg::MAX_READ ||
                 32'(c.read_count) > 32'(ring_held)) begin
      word_results.push_back(ring_result(1'b0, 1'b0, '0, 1'b1));
    end else if (c.read_count == '0) begin
      word_results.push_back(ring_result(1'b1, 1'b0, '0, 1'b1));
    end else begin
      for (int unsigned i = 0; i < 32'(c.read_count); i++) begin
        v = ring_mem[ring_rd];
        ring_rd = advance_slot(ring_rd, cap);
        ring_held--;
        word_results.push_back(ring_result(1'b1, 1'b1, v, (i + 1 == 32'(c.read_count))));
      end
    end
  endtask

  // Offers one word after an optional pause and records what it must produce.
  task automatic send_item(srb_pkg::cmd_t c, int unsigned gap, bit typed, srb_pkg::res_t want);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    predict_ring_results(c);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (word_results[i]) pending_results.push_back(word_results[i]);
    end
  endtask

  // Holds off new words until every expected result has come, then waits a little more.
  task automatic wait_for_results(int unsigned settle);
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [srb_pkg::CAP_W-1:0] c);
    wait_for_results(3);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    empty_ring(c);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic stim_row_t item_row(srb_pkg::func_e f, logic [srb_pkg::SAMPLE_W-1:0] s,
                                         logic [srb_pkg::RC_W-1:0] n, bit typed, logic ok,
                                         logic [srb_pkg::CAP_W-1:0] occ,
                                         logic [srb_pkg::DROP_W-1:0] drops);
    stim_row_t r;
    r.kind  = ROW_WORD;
    r.cmd   = srb_pkg::cmd_t'{func: f, sample_in: s, read_count: n};
    r.cap   = '0;
    r.typed = typed;
    r.want  = srb_pkg::res_t'{ok: ok, has_sample: 1'b0, sample_out: '0, last: 1'b1,
                              occupancy: occ, dropped_total: drops};
    return r;
  endfunction

  function automatic stim_row_t cap_row(logic [srb_pkg::CAP_W-1:0] c);
    stim_row_t r;
    r.kind  = ROW_CAP;
    r.cmd   = '0;
    r.cap   = c;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  // Random word: write_pct% writes; reads mostly fit the fill, some oversized or random.
  function automatic srb_pkg::cmd_t pick_item(int unsigned write_pct);
    srb_pkg::cmd_t c;
    int unsigned   top;
    int unsigned   r;
    c.sample_in  = $urandom();
    c.read_count = srb_pkg::RC_W'($urandom_range(0, 127));
    if ($urandom_range(0, 9) == 0) c.sample_in = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 99) < write_pct) begin
      c.func = srb_pkg::FUNC_WRITE;
    end else begin
      c.func = srb_pkg::FUNC_READ;
      top = (32'(ring_held) < srb_pkg::MAX_READ) ? 32'(ring_held) : srb_pkg::MAX_READ;
      r = $urandom_range(0, 9);
      if (r < 7) c.read_count = srb_pkg::RC_W'($urandom_range(0, top));
      else if (r == 9) c.read_count = srb_pkg::RC_W'(srb_pkg::MAX_READ);
    end
    return c;
  endfunction

  // Result checker: every strobed word must match the oldest expectation.
  always @(posedge clk_i) begin
    srb_pkg::res_t want;
    if (rst_ni && res_strobe_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: unexpected result ok=%b has=%b sample=%h last=%b occ=%0d drops=%0d",
                   $realtime, res_o.ok, res_o.has_sample, res_o.sample_out, res_o.last,
                   res_o.occupancy, res_o.dropped_total);
      end else begin
        want = pending_results.pop_front();
        if (res_o !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $write("%0t: expected ok=%b has=%b sample=%h last=%b occ=%0d drops=%0d",
                   $realtime, want.ok, want.has_sample, want.sample_out, want.last,
                   want.occupancy, want.dropped_total);
            $display(", got ok=%b has=%b sample=%h last=%b occ=%0d drops=%0d",
                     res_o.ok, res_o.has_sample, res_o.sample_out, res_o.last,
                     res_o.occupancy, res_o.dropped_total);
          end
        end
      end
    end
  end

  // Watchdog against a hang.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("sample_ring_buffer_test NOT OK");
      $finish;
    end
  end

  initial begin
    stim_row_t                 rows[$];
    logic [srb_pkg::CAP_W-1:0] phase_caps[$];
    srb_pkg::cmd_t             c;
    bit                        steady;
    int unsigned               pct;

    rst_ni      <= 1'b0;
    start       <= 1'b0;
    cmd_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    empty_ring(srb_pkg::CAP_RESET);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: empty ring after reset, data extremes, oversized reads,
    // capacity below one and above the depth, drops and slot wrap.
    rows.push_back(item_row(srb_pkg::FUNC_READ,  32'h5A5A_5A5A, 7'd0,   1'b1, 1'b1, 11'd0,
                            32'd0));
    rows.push_back(item_row(srb_pkg::FUNC_READ,  32'h0000_0000, 7'd1,   1'b1, 1'b0, 11'd0,
                            32'd0));
    rows.push_back(item_row(srb_pkg::FUNC_READ,  32'hFFFF_FFFF, 7'd127, 1'b1, 1'b0, 11'd0,
                            32'd0));
    rows.push_back(item_row(srb_pkg::FUNC_WRITE, 32'h0000_0000, 7'd127, 1'b1, 1'b1, 11'd1,
                            32'd0));
    rows.push_back(item_row(srb_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 7'd0,   1'b1, 1'b1, 11'd2,
                            32'd0));
    rows.push_back(item_row(srb_pkg::FUNC_WRITE, 32'h7F80_0000, 7'd5,   1'b1, 1'b1, 11'd3,
                            32'd0));
    rows.push_back(item_row(srb_pkg::FUNC_READ,  32'h0000_0000, 7'd65,  1'b1, 1'b0, 11'd3,
                            32'd0));
    rows.push_back(item_row(srb_pkg::FUNC_READ,  32'h0000_0000, 7'd3,   1'b0, 1'b0, 11'd0,
                            32'd0));
    rows.push_back(item_row(srb_pkg::FUNC_READ,  32'h0000_0000, 7'd0,   1'b1, 1'b1, 11'd0,
                            32'd0));
    rows.push_back(cap_row(11'd0));
    rows.push_back(item_row(srb_pkg::FUNC_WRITE, 32'h1234_5678, 7'd0,   1'b1, 1'b1, 11'd1,
                            32'd0));
    rows.push_back(item_row(srb_pkg::FUNC_WRITE, 32'h9ABC_DEF0, 7'd0,   1'b1, 1'b0, 11'd1,
                            32'd1));
    rows.push_back(item_row(srb_pkg::FUNC_WRITE, 32'h0000_0000, 7'd0,   1'b1, 1'b0, 11'd1,
                            32'd2));
    rows.push_back(item_row(srb_pkg::FUNC_READ,  32'h0000_0000, 7'd2,   1'b1, 1'b0, 11'd1,
                            32'd2));
    rows.push_back(item_row(srb_pkg::FUNC_READ,  32'h0000_0000, 7'd1,   1'b0, 1'b0, 11'd0,
                            32'd0));
    rows.push_back(cap_row(11'd2047));
    rows.push_back(item_row(srb_pkg::FUNC_WRITE, 32'h8000_0000, 7'd0,   1'b1, 1'b1, 11'd1,
                            32'd2));
    rows.push_back(item_row(srb_pkg::FUNC_READ,  32'h0000_0000, 7'd64,  1'b1, 1'b0, 11'd1,
                            32'd2));
    rows.push_back(cap_row(11'd2));
    rows.push_back(item_row(srb_pkg::FUNC_WRITE, 32'h0000_0001, 7'd0,   1'b1, 1'b1, 11'd1,
                            32'd2));
    rows.push_back(item_row(srb_pkg::FUNC_WRITE, 32'h0000_0002, 7'd0,   1'b1, 1'b1, 11'd2,
                            32'd2));
    rows.push_back(item_row(srb_pkg::FUNC_WRITE, 32'h0000_0003, 7'd0,   1'b1, 1'b0, 11'd2,
                            32'd3));
    rows.push_back(item_row(srb_pkg::FUNC_READ,  32'h0000_0000, 7'd2,   1'b0, 1'b0, 11'd0,
                            32'd0));
    rows.push_back(item_row(srb_pkg::FUNC_WRITE, 32'h0000_0004, 7'd0,   1'b1, 1'b1, 11'd1,
                            32'd3));
    rows.push_back(item_row(srb_pkg::FUNC_READ,  32'h0000_0000, 7'd1,   1'b0, 1'b0, 11'd0,
                            32'd0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CAP) write_capacity(rows[i].cap);
      else send_item(rows[i].cmd, $urandom_range(0, 8), rows[i].typed, rows[i].want);
    end

    // Random phases over several capacities; each phase drains once midway.
    phase_caps = '{11'd1, 11'd3, 11'd2, 11'd7, 11'd16, 11'd1024, 11'd1500, 11'd5, 11'd40};
    phase_caps.push_back(srb_pkg::CAP_W'($urandom_range(1, 12)));
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      steady = ($urandom_range(0, 3) == 0);
      pct = (phase_caps[p] > 11'd100) ? 75 : 50;
      for (int unsigned i = 0; i < 14; i++) begin
        if (i == 7) wait_for_results(0);
        send_item(pick_item(pct), steady ? 0 : $urandom_range(0, 8), 1'b0, '0);
      end
    end

    // Fill past the longest read, then take the longest read and the remainder.
    write_capacity(srb_pkg::CAP_RESET);
    for (int unsigned i = 0; i < 65; i++) begin
      c = pick_item(100);
      send_item(c, (i < 32) ? 0 : $urandom_range(0, 8), 1'b0, '0);
    end
    c = srb_pkg::cmd_t'{func: srb_pkg::FUNC_READ, sample_in: $urandom(),
                        read_count: srb_pkg::RC_W'(srb_pkg::MAX_READ)};
    send_item(c, $urandom_range(0, 8), 1'b0, '0);
    c.read_count = 7'd1;
    send_item(c, 0, 1'b0, '0);

    wait_for_results(8);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("sample_ring_buffer_test OK");
    end else begin
      $display("sample_ring_buffer_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/srb_pkg.sv
rtl/core/srb_ram.sv
rtl/core/srb_ctrl.sv
rtl/core/sample_ring_buffer.sv
tb/sv/sample_ring_buffer_test.sv
